// File: rtl/ilsm_pkg.sv
// Package for the indexed list slot manager: constants, codes, payload types and helpers.
`default_nettype none

package ilsm_pkg;

  // Table size and the width of a slot number.
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned DEPTH    = CAPACITY + 1;
  localparam int unsigned IDX_W    = $clog2(DEPTH);

  // Operation codes of a request.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Kind of work decided when a request is accepted.
  typedef enum logic [2:0] {
    K_INS_EMPTY,
    K_INS_NEW,
    K_INS_FREE,
    K_DEL_FIRST,
    K_DEL_LAST,
    K_DEL_MID
  } kind_e;

  // Sequencer states: one link write per memory per step.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LINK,
    S_TAIL,
    S_FREE
  } state_e;

  typedef logic [IDX_W-1:0] idx_t;

  // Request payload.
  typedef struct packed {
    logic opcode;
    idx_t slot_index;
  } req_t;

  // Result payload.
  typedef struct packed {
    idx_t        slot;
    logic [1:0]  status;
    idx_t        first_live;
    idx_t        last_live;
  } rsp_t;

  // Slot numbers above the capacity fold onto entry zero.
  function automatic idx_t bound(input idx_t i);
    return (i > IDX_W'(CAPACITY)) ? '0 : i;
  endfunction

endpackage

`default_nettype wire

// File: rtl/indexed_list_slot_manager.sv
// Top level of the indexed list slot manager: sequencer, list registers and link memories.
`default_nettype none

// A request is taken when start_i is high and busy_o is low. Rejected requests
// (table full, delete on an empty table, index out of range) and the delete of
// the only live slot are answered in S_IDLE; an insert into an empty table uses
// S_LINK, other inserts and deletes S_LINK and S_TAIL, deletes also S_FREE
// when the free list is not empty. The steps follow from the two single-port
// link memories (next and previous), each taking one read or one write per
// cycle, and the sequencer's dependent link writes. The result is shown for
// exactly one cycle under done_o and cannot be held off by the receiver;
// busy_o is low in that cycle, so the next request may be taken at once.
module indexed_list_slot_manager (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  ilsm_pkg::req_t        req_i,
  output logic                  busy_o,
  output logic                  done_o,
  output ilsm_pkg::rsp_t        rsp_o
);

  // List registers.
  ilsm_pkg::idx_t first_q, first_d;
  ilsm_pkg::idx_t last_q, last_d;
  ilsm_pkg::idx_t free_q, free_d;
  ilsm_pkg::idx_t hw_q, hw_d;

  // Sequencer and per-request registers.
  ilsm_pkg::state_e  state_q, state_d;
  ilsm_pkg::kind_e   kind_q, kind_d;
  ilsm_pkg::idx_t    slot_q, slot_d;
  ilsm_pkg::idx_t    res_slot_q, res_slot_d;
  ilsm_pkg::status_e res_status_q, res_status_d;
  logic              done_q, done_d;

  // Link memory ports.
  logic           nx_we, pv_we, rd_en;
  ilsm_pkg::idx_t nx_wa, nx_wd, pv_wa, pv_wd, nx_ra, pv_ra;
  ilsm_pkg::idx_t nx_rd_q, pv_rd_q;

  ilsm_pkg::idx_t next_mem [ilsm_pkg::DEPTH];
  ilsm_pkg::idx_t prev_mem [ilsm_pkg::DEPTH];

  logic accept;
  assign accept = start_i && (state_q == ilsm_pkg::S_IDLE);

  // Next-link memory: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[ilsm_pkg::bound(nx_wa)] <= ilsm_pkg::bound(nx_wd);
    end
    if (rd_en) begin
      nx_rd_q <= next_mem[ilsm_pkg::bound(nx_ra)];
    end
  end

  // Previous-link memory: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (pv_we) begin
      prev_mem[ilsm_pkg::bound(pv_wa)] <= ilsm_pkg::bound(pv_wd);
    end
    if (rd_en) begin
      pv_rd_q <= prev_mem[ilsm_pkg::bound(pv_ra)];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ilsm_pkg::S_IDLE;
      first_q <= ilsm_pkg::idx_t'(1);
      last_q  <= '0;
      free_q  <= '0;
      hw_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      last_q  <= last_d;
      free_q  <= free_d;
      hw_q    <= hw_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    slot_q       <= slot_d;
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
  end

  // Sequencer: classify on accept, then answer at once or step through the link writes.
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    slot_d       = slot_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    done_d       = 1'b0;
    first_d      = first_q;
    last_d       = last_q;
    free_d       = free_q;
    hw_d         = hw_q;
    rd_en        = 1'b0;
    nx_ra        = req_i.slot_index;
    pv_ra        = req_i.slot_index;
    nx_we        = 1'b0;
    nx_wa        = slot_q;
    nx_wd        = '0;
    pv_we        = 1'b0;
    pv_wa        = slot_q;
    pv_wd        = '0;

    case (state_q)
      ilsm_pkg::S_IDLE: begin
        if (accept) begin
          rd_en        = 1'b1;
          res_status_d = ilsm_pkg::ST_OK;
          if (req_i.opcode == ilsm_pkg::OP_INSERT) begin
            if (last_q == '0) begin
              kind_d  = ilsm_pkg::K_INS_EMPTY;
              slot_d  = ilsm_pkg::idx_t'(1);
              state_d = ilsm_pkg::S_LINK;
            end else if (free_q != '0) begin
              kind_d  = ilsm_pkg::K_INS_FREE;
              slot_d  = free_q;
              nx_ra   = free_q;
              state_d = ilsm_pkg::S_LINK;
            end else if (hw_q >= ilsm_pkg::IDX_W'(ilsm_pkg::CAPACITY)) begin
              res_slot_d   = '0;
              res_status_d = ilsm_pkg::ST_FULL;
              done_d       = 1'b1;
            end else begin
              kind_d  = ilsm_pkg::K_INS_NEW;
              slot_d  = hw_q + ilsm_pkg::idx_t'(1);
              state_d = ilsm_pkg::S_LINK;
            end
          end else begin
            slot_d = req_i.slot_index;
            if (last_q == '0) begin
              res_slot_d   = '0;
              res_status_d = ilsm_pkg::ST_EMPTY;
              done_d       = 1'b1;
            end else if ((req_i.slot_index == '0) || (req_i.slot_index > hw_q)) begin
              res_slot_d   = '0;
              res_status_d = ilsm_pkg::ST_RANGE;
              done_d       = 1'b1;
            end else if (req_i.slot_index == first_q) begin
              if (first_q == last_q) begin
                // Deleting the only live slot empties the whole table.
                first_d    = ilsm_pkg::idx_t'(1);
                last_d     = '0;
                free_d     = '0;
                hw_d       = '0;
                res_slot_d = req_i.slot_index;
                done_d     = 1'b1;
              end else begin
                kind_d  = ilsm_pkg::K_DEL_FIRST;
                nx_ra   = first_q;
                state_d = ilsm_pkg::S_LINK;
              end
            end else if (req_i.slot_index == last_q) begin
              kind_d  = ilsm_pkg::K_DEL_LAST;
              pv_ra   = last_q;
              state_d = ilsm_pkg::S_LINK;
            end else begin
              kind_d  = ilsm_pkg::K_DEL_MID;
              state_d = ilsm_pkg::S_LINK;
            end
          end
        end
      end

      ilsm_pkg::S_LINK: begin
        state_d = ilsm_pkg::S_TAIL;
        case (kind_q)
          ilsm_pkg::K_INS_EMPTY: begin
            nx_we      = 1'b1;
            pv_we      = 1'b1;
            hw_d       = ilsm_pkg::idx_t'(1);
            first_d    = ilsm_pkg::idx_t'(1);
            last_d     = ilsm_pkg::idx_t'(1);
            res_slot_d = slot_q;
            done_d     = 1'b1;
            state_d    = ilsm_pkg::S_IDLE;
          end
          ilsm_pkg::K_INS_NEW, ilsm_pkg::K_INS_FREE: begin
            // New tail entry: no successor, predecessor is the old tail.
            nx_we = 1'b1;
            pv_we = 1'b1;
            pv_wd = last_q;
            if (kind_q == ilsm_pkg::K_INS_FREE) begin
              free_d = nx_rd_q;
            end
          end
          ilsm_pkg::K_DEL_FIRST: begin
            pv_we   = 1'b1;
            pv_wa   = nx_rd_q;
            first_d = nx_rd_q;
          end
          ilsm_pkg::K_DEL_LAST: begin
            nx_we  = 1'b1;
            nx_wa  = pv_rd_q;
            last_d = pv_rd_q;
          end
          default: begin
            // Middle slot: join its neighbours to each other.
            nx_we = 1'b1;
            nx_wa = pv_rd_q;
            nx_wd = nx_rd_q;
            pv_we = 1'b1;
            pv_wa = nx_rd_q;
            pv_wd = pv_rd_q;
          end
        endcase
      end

      ilsm_pkg::S_TAIL: begin
        res_slot_d = slot_q;
        if ((kind_q == ilsm_pkg::K_INS_NEW) || (kind_q == ilsm_pkg::K_INS_FREE)) begin
          // Hook the new slot behind the old tail.
          nx_we  = 1'b1;
          nx_wa  = last_q;
          nx_wd  = slot_q;
          last_d = slot_q;
          if (kind_q == ilsm_pkg::K_INS_NEW) begin
            hw_d = slot_q;
          end
          done_d  = 1'b1;
          state_d = ilsm_pkg::S_IDLE;
        end else begin
          // Push the deleted slot onto the free list.
          pv_we = 1'b1;
          nx_we = 1'b1;
          nx_wd = free_q;
          if (free_q == '0) begin
            free_d  = slot_q;
            done_d  = 1'b1;
            state_d = ilsm_pkg::S_IDLE;
          end else begin
            state_d = ilsm_pkg::S_FREE;
          end
        end
      end

      ilsm_pkg::S_FREE: begin
        // Old free head points back at the slot just released.
        pv_we      = 1'b1;
        pv_wa      = free_q;
        pv_wd      = slot_q;
        free_d     = slot_q;
        res_slot_d = slot_q;
        done_d     = 1'b1;
        state_d    = ilsm_pkg::S_IDLE;
      end

      default: begin
        state_d = ilsm_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  assign busy_o            = (state_q != ilsm_pkg::S_IDLE);
  assign done_o            = done_q;
  assign rsp_o.slot        = res_slot_q;
  assign rsp_o.status      = res_status_q;
  assign rsp_o.first_live  = (last_q == '0) ? '0 : first_q;
  assign rsp_o.last_live   = last_q;

  // A result is only shown once the sequencer is back at rest.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while the sequencer is busy");

  // An accepted request either starts the link sequence or answers at once.
  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted request neither started nor answered");

  // A successful operation always names a real slot.
  a_ok_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == ilsm_pkg::ST_OK)) |-> (rsp_o.slot != '0))
    else $error("successful result with slot zero");

  // The high-water mark never passes the capacity.
  a_hw_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= ilsm_pkg::IDX_W'(ilsm_pkg::CAPACITY))
    else $error("high-water mark beyond capacity");

endmodule

`default_nettype wire

// File: tb/indexed_list_slot_manager_tb.sv
// Self-checking testbench for the indexed list slot manager with a built-in table predictor.
`timescale 1ns / 1ps

module indexed_list_slot_manager_tb;

  localparam int unsigned CAP            = ilsm_pkg::CAPACITY;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  ilsm_pkg::req_t req_i = '0;
  logic busy_o;
  logic done_o;
  ilsm_pkg::rsp_t rsp_o;

  // Predicted table: link stores, list ends, free list head and high-water mark.
  ilsm_pkg::idx_t nxt_tbl [0:CAP];
  ilsm_pkg::idx_t prv_tbl [0:CAP];
  ilsm_pkg::idx_t head_slot = ilsm_pkg::idx_t'(1);
  ilsm_pkg::idx_t tail_slot = '0;
  ilsm_pkg::idx_t free_top  = '0;
  ilsm_pkg::idx_t hw_mark   = '0;

  // Results still owed by the block, oldest first, and the slots believed live.
  ilsm_pkg::rsp_t expected_rsp [$];
  ilsm_pkg::idx_t live_slots [$];

  int unsigned err_count   = 0;
  int unsigned idle_cycles = 0;
  int unsigned quiet_left  = 0;

  indexed_list_slot_manager DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  always #4 clk_i = ~clk_i;

  // Slot numbers beyond the table land on entry zero.
  function automatic ilsm_pkg::idx_t fold_slot(input ilsm_pkg::idx_t i);
    return (i > CAP) ? '0 : i;
  endfunction

  // Applies one request to the predicted table and returns the result it should give.
  function automatic ilsm_pkg::rsp_t predict_table_op(input ilsm_pkg::req_t rq);
    ilsm_pkg::rsp_t r;
    ilsm_pkg::idx_t s;
    ilsm_pkg::idx_t p;
    ilsm_pkg::idx_t n;
    ilsm_pkg::idx_t h;
    r = '0;
    r.status = ilsm_pkg::ST_OK;
    if (rq.opcode == ilsm_pkg::OP_INSERT) begin
      if (tail_slot == '0) begin
        // Empty table: start afresh at slot one.
        hw_mark = ilsm_pkg::idx_t'(1);
        head_slot = ilsm_pkg::idx_t'(1);
        tail_slot = ilsm_pkg::idx_t'(1);
        nxt_tbl[1] = '0;
        prv_tbl[1] = '0;
        r.slot = ilsm_pkg::idx_t'(1);
      end else if (free_top == '0 && hw_mark >= CAP) begin
        r.status = ilsm_pkg::ST_FULL;
      end else begin
        if (free_top == '0) begin
          s = hw_mark + ilsm_pkg::idx_t'(1);
          hw_mark = s;
        end else begin
          s = free_top;
          free_top = nxt_tbl[fold_slot(s)];
        end
        nxt_tbl[fold_slot(s)] = '0;
        prv_tbl[fold_slot(s)] = fold_slot(tail_slot);
        nxt_tbl[fold_slot(tail_slot)] = fold_slot(s);
        tail_slot = s;
        r.slot = s;
      end
    end else begin
      h = rq.slot_index;
      if (tail_slot == '0) begin
        r.status = ilsm_pkg::ST_EMPTY;
      end else if (h == '0 || h > hw_mark) begin
        r.status = ilsm_pkg::ST_RANGE;
      end else begin
        r.slot = h;
        if (h == head_slot && head_slot == tail_slot) begin
          // Removing the last live slot clears the whole table.
          head_slot = ilsm_pkg::idx_t'(1);
          tail_slot = '0;
          free_top = '0;
          hw_mark = '0;
        end else begin
          if (h == head_slot) begin
            head_slot = nxt_tbl[fold_slot(head_slot)];
            prv_tbl[fold_slot(head_slot)] = '0;
          end else if (h == tail_slot) begin
            tail_slot = prv_tbl[fold_slot(tail_slot)];
            nxt_tbl[fold_slot(tail_slot)] = '0;
          end else begin
            p = prv_tbl[fold_slot(h)];
            n = nxt_tbl[fold_slot(h)];
            nxt_tbl[fold_slot(p)] = fold_slot(n);
            prv_tbl[fold_slot(n)] = fold_slot(p);
          end
          // Push the released slot onto the free list.
          prv_tbl[fold_slot(h)] = '0;
          if (free_top == '0) begin
            nxt_tbl[fold_slot(h)] = '0;
          end else begin
            nxt_tbl[fold_slot(h)] = fold_slot(free_top);
            prv_tbl[fold_slot(free_top)] = fold_slot(h);
          end
          free_top = h;
        end
      end
    end
    r.first_live = (tail_slot == '0) ? '0 : head_slot;
    r.last_live = tail_slot;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      err_count++;
      if (err_count <= 40) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endfunction

  // Sends one request after a random gap and records the result it should produce.
  task automatic issue_op(input logic op, input ilsm_pkg::idx_t idx);
    int unsigned gap;
    int unsigned k;
    ilsm_pkg::req_t rq;
    ilsm_pkg::rsp_t want;
    if (quiet_left > 0) begin
      gap = 0;
      quiet_left--;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 24) == 0) quiet_left = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rq.opcode = op;
    rq.slot_index = idx;
    start_i <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    want = predict_table_op(rq);
    expected_rsp.push_back(want);
    // Keep the list of live slots in step with well-formed traffic.
    if (want.status == ilsm_pkg::ST_OK) begin
      if (op == ilsm_pkg::OP_INSERT) begin
        live_slots.push_back(want.slot);
      end else begin
        for (k = 0; k < live_slots.size(); k++) begin
          if (live_slots[k] == want.slot) begin
            live_slots.delete(k);
            break;
          end
        end
      end
    end
  endtask

  function automatic ilsm_pkg::idx_t any_index();
    return ilsm_pkg::idx_t'($urandom_range(0, 2047));
  endfunction

  // Empty-table errors, range errors, deletes at head, tail and middle, free-list reuse.
  task automatic test_directed_cases();
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(5));
    issue_op(ilsm_pkg::OP_DELETE, '0);
    issue_op(ilsm_pkg::OP_INSERT, ilsm_pkg::idx_t'(2047));
    repeat (4) issue_op(ilsm_pkg::OP_INSERT, '0);
    issue_op(ilsm_pkg::OP_DELETE, '0);
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(6));
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(2047));
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(1024));
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(3));
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(1));
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(5));
    repeat (4) issue_op(ilsm_pkg::OP_INSERT, ilsm_pkg::idx_t'(1365));
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(2));
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(4));
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(5));
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(1));
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(3));
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(6));
  endtask

  // Well-formed inserts and deletes with some bad requests mixed in.
  task automatic test_mixed_traffic(input int unsigned count);
    int unsigned i;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned pos;
    ilsm_pkg::idx_t idx;
    ins_pct = 50;
    for (i = 0; i < count; i++) begin
      if (i % 50 == 0) ins_pct = 35 + 15 * $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        // Index zero or above the high-water mark, never a stale in-range slot.
        if ($urandom_range(0, 3) == 0) idx = '0;
        else idx = ilsm_pkg::idx_t'($urandom_range(int'(hw_mark) + 1, 2047));
        issue_op(ilsm_pkg::OP_DELETE, idx);
      end else if (live_slots.size() == 0 || roll < 12 + ins_pct) begin
        issue_op(ilsm_pkg::OP_INSERT, any_index());
      end else begin
        case ($urandom_range(0, 2))
          0:       pos = 0;
          1:       pos = live_slots.size() - 1;
          default: pos = $urandom_range(0, live_slots.size() - 1);
        endcase
        issue_op(ilsm_pkg::OP_DELETE, live_slots[pos]);
      end
    end
  endtask

  // Fill every slot, knock on the full table, then churn through the free list.
  task automatic test_fill_to_capacity();
    int unsigned i;
    while (!(free_top == '0 && hw_mark >= CAP)) issue_op(ilsm_pkg::OP_INSERT, any_index());
    repeat (3) issue_op(ilsm_pkg::OP_INSERT, any_index());
    issue_op(ilsm_pkg::OP_DELETE, ilsm_pkg::idx_t'(1024));
    for (i = 0; i < 10; i++) begin
      issue_op(ilsm_pkg::OP_DELETE, live_slots[$urandom_range(0, live_slots.size() - 1)]);
    end
    repeat (11) issue_op(ilsm_pkg::OP_INSERT, any_index());
    repeat (2) issue_op(ilsm_pkg::OP_INSERT, any_index());
  endtask

  // Deletes of slots that are already free, mixed with ordinary traffic.
  task automatic test_blind_delete();
    ilsm_pkg::idx_t freed [$];
    int unsigned i;
    for (i = 0; i < 8; i++) begin
      freed.push_back(live_slots[$urandom_range(0, live_slots.size() - 1)]);
      issue_op(ilsm_pkg::OP_DELETE, freed[$]);
    end
    for (i = 0; i < 40; i++) begin
      case ($urandom_range(0, 2))
        0: issue_op(ilsm_pkg::OP_DELETE, freed[$urandom_range(0, freed.size() - 1)]);
        1: issue_op(ilsm_pkg::OP_INSERT, any_index());
        default: begin
          if (hw_mark == '0) begin
            issue_op(ilsm_pkg::OP_INSERT, any_index());
          end else begin
            issue_op(ilsm_pkg::OP_DELETE,
                     ilsm_pkg::idx_t'($urandom_range(1, int'(hw_mark))));
          end
        end
      endcase
    end
  endtask

  // Compare every result with the oldest outstanding request.
  always @(posedge clk_i) begin : check_results
    ilsm_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        err_count++;
        if (err_count <= 40) begin
          $display("%0t: result with no request outstanding, expected none, actual slot %0d",
                   $time, rsp_o.slot);
        end
      end else begin
        want = expected_rsp.pop_front();
        check_field("slot", 32'(want.slot), 32'(rsp_o.slot));
        check_field("status", 32'(want.status), 32'(rsp_o.status));
        check_field("first_live", 32'(want.first_live), 32'(rsp_o.first_live));
        check_field("last_live", 32'(want.last_live), 32'(rsp_o.last_live));
      end
    end
  end

  // Stop the run if neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("indexed_list_slot_manager_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_mixed_traffic(450);
    test_fill_to_capacity();
    test_blind_delete();
    start_i <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("indexed_list_slot_manager_tb OK");
    end else begin
      $display("indexed_list_slot_manager_tb NOT OK");
    end
    $finish;
  end

endmodule
